@@ rtl/lts_pkg.sv @@
// Shared types and constants for the Lox token scanner.
`default_nettype none

package lts_pkg;

   // Result field widths
   localparam int START_W  = 24;
   localparam int LENGTH_W = 16;
   localparam int LINE_W   = 20;
   localparam int COLUMN_W = 16;
   localparam int ERRCNT_W = 16;
   localparam int MAX_RESULTS = 3;

   localparam logic [START_W-1:0]  START_MAX  = '1;
   localparam logic [LINE_W-1:0]   LINE_MAX   = '1;
   localparam logic [COLUMN_W-1:0] COLUMN_MAX = '1;

   // Token kinds
   localparam logic [4:0] KIND_LPAREN    = 5'd0;
   localparam logic [4:0] KIND_RPAREN    = 5'd1;
   localparam logic [4:0] KIND_LBRACE    = 5'd2;
   localparam logic [4:0] KIND_RBRACE    = 5'd3;
   localparam logic [4:0] KIND_COMMA     = 5'd4;
   localparam logic [4:0] KIND_DOT       = 5'd5;
   localparam logic [4:0] KIND_MINUS     = 5'd6;
   localparam logic [4:0] KIND_PLUS      = 5'd7;
   localparam logic [4:0] KIND_SEMI      = 5'd8;
   localparam logic [4:0] KIND_STAR      = 5'd9;
   localparam logic [4:0] KIND_SLASH     = 5'd10;
   localparam logic [4:0] KIND_STRING    = 5'd11;
   localparam logic [4:0] KIND_EQ_EQ     = 5'd12;
   localparam logic [4:0] KIND_NUMBER    = 5'd20;
   localparam logic [4:0] KIND_EOF       = 5'd21;
   localparam logic [4:0] KIND_BAD_CHAR  = 5'd22;
   localparam logic [4:0] KIND_UNTERM    = 5'd23;

   // Pending operator codes
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_EQ   = 3'd1;
   localparam logic [2:0] OP_BANG = 3'd2;
   localparam logic [2:0] OP_GT   = 3'd3;
   localparam logic [2:0] OP_LT   = 3'd4;

   // Characters
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef struct packed {
      logic                last;
      logic [4:0]          kind;
      logic [START_W-1:0]  start;
      logic [LENGTH_W-1:0] length;
      logic [LINE_W-1:0]   line;
      logic [COLUMN_W-1:0] column;
      logic [7:0]          bad;
      logic [ERRCNT_W-1:0] errors;
   } rsp_type;

   // Results caused by one input transfer
   typedef struct packed {
      logic [1:0]                  count;
      rsp_type [MAX_RESULTS-1:0]   item;
   } scan_out_type;

   // Kind of a comparison operator; unknown codes fall back to '='
   function automatic logic [4:0] op_kind(input logic [2:0] op, input logic two);
      logic [2:0] p;
      logic [4:0] base;
      p    = (op >= OP_EQ && op <= OP_LT) ? op : OP_EQ;
      base = KIND_EQ_EQ + {1'b0, p - OP_EQ, 1'b0};
      return base + {4'd0, ~two};
   endfunction

endpackage

`default_nettype wire

@@ rtl/lox_token_scanner.sv @@
// Top level of the Lox token scanner: stream ports, scan core and result queue.
// A transfer's results are registered in the result queue, then offered on rsp_.
// Throughput: one byte per cycle while req_tready is high; an item giving up to 3
//   results sends them one per rsp_ transfer, and req_tready drops while the 4-entry
//   result queue holds more than one result.
// Reset: synchronous, active high; clears scan mode, positions, error count, queue.
`default_nettype none

module lox_token_scanner #(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,

   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // [7:0] ch
   input  wire logic [0:0]    req_tuser,   // [0] is_end

   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [103:0]       rsp_tdata,   // [23:0] start_offset, [39:24] token_length,
                                           // [59:40] line, [75:60] column,
                                           // [83:76] bad_char, [99:84] error_count
   output logic [4:0]         rsp_tuser,   // [4:0] token_kind
   output logic               rsp_tlast    // last result caused by one source transfer
);
   import lts_pkg::*;

   logic         req_accept;
   scan_out_type scan_out;
   rsp_type      head;

   assign req_accept = req_tvalid && req_tready;

   // Scan state advances on each accepted transfer; its results land in the queue
   lts_scan_core #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_ch     (req_tdata),
      .in_is_end (req_tuser[0]),
      .scan_out  (scan_out)
   );

   // Ready only when a worst-case burst of results fits
   lts_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .wr        (scan_out),
      .space_ok  (req_tready),
      .out_valid (rsp_tvalid),
      .out_item  (head),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {4'b0000, head.errors, head.bad, head.column, head.line,
                       head.length, head.start};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire

@@ rtl/lts_scan_core.sv @@
// Scanner state and the per-byte token logic.
`default_nettype none

module lts_scan_core #(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_accept,
   input  wire logic [7:0]           in_ch,
   input  wire logic                 in_is_end,
   output lts_pkg::scan_out_type     scan_out
);
   import lts_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_SLASH   = 3'd1,
      MODE_COMMENT = 3'd2,
      MODE_STRING  = 3'd3,
      MODE_INT     = 3'd4,
      MODE_FRAC    = 3'd5,
      MODE_OP      = 3'd6
   } mode_type;

   localparam int OW = (OFFSET_BITS > START_W)  ? OFFSET_BITS : START_W;
   localparam int LW = (LINE_BITS   > LINE_W)   ? LINE_BITS   : LINE_W;
   localparam int CW = (COLUMN_BITS > COLUMN_W) ? COLUMN_BITS : COLUMN_W;

   mode_type               mode_ff, mode_in;
   logic [2:0]             op_ff, op_in;
   logic [OFFSET_BITS-1:0] tok_start_ff, tok_start_in;
   logic [LINE_BITS-1:0]   tok_line_ff, tok_line_in;
   logic [COLUMN_BITS-1:0] tok_col_ff, tok_col_in;
   logic [LENGTH_W-1:0]    tok_len_ff, tok_len_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [ERRCNT_W-1:0]    err_ff, err_in;

   rsp_type [MAX_RESULTS-1:0] res;
   logic [1:0]                n;
   logic                      fall;
   logic                      is_digit;

   function automatic logic [START_W-1:0] clamp_off(input logic [OFFSET_BITS-1:0] v);
      logic [OW-1:0] e;
      e = OW'(v);
      return (e > OW'(START_MAX)) ? START_MAX : e[START_W-1:0];
   endfunction

   function automatic logic [LINE_W-1:0] clamp_line(input logic [LINE_BITS-1:0] v);
      logic [LW-1:0] e;
      e = LW'(v);
      return (e > LW'(LINE_MAX)) ? LINE_MAX : e[LINE_W-1:0];
   endfunction

   function automatic logic [COLUMN_W-1:0] clamp_col(input logic [COLUMN_BITS-1:0] v);
      logic [CW-1:0] e;
      e = CW'(v);
      return (e > CW'(COLUMN_MAX)) ? COLUMN_MAX : e[COLUMN_W-1:0];
   endfunction

   function automatic rsp_type make_rsp(
      input logic [4:0]             kind,
      input logic [OFFSET_BITS-1:0] st,
      input logic [LENGTH_W-1:0]    len,
      input logic [LINE_BITS-1:0]   ln,
      input logic [COLUMN_BITS-1:0] col,
      input logic [7:0]             bad,
      input logic [ERRCNT_W-1:0]    errs
   );
      rsp_type r;
      r.last   = 1'b0;
      r.kind   = kind;
      r.start  = clamp_off(st);
      r.length = len;
      r.line   = clamp_line(ln);
      r.column = clamp_col(col);
      r.bad    = bad;
      r.errors = errs;
      return r;
   endfunction

   function automatic logic [LENGTH_W-1:0] len_inc(input logic [LENGTH_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Position advances once per source byte, after any tokens it closes
   always_comb begin
      offset_in = offset_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      if (!in_is_end) begin
         offset_in = (offset_ff == '1) ? offset_ff : offset_ff + 1'b1;
         if (in_ch == CH_NL) begin
            line_in = (line_ff == '1) ? line_ff : line_ff + 1'b1;
            col_in  = '0;
         end else begin
            col_in = (col_ff == '1) ? col_ff : col_ff + 1'b1;
         end
      end
   end

   assign is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);

   always_comb begin
      mode_in      = mode_ff;
      op_in        = op_ff;
      tok_start_in = tok_start_ff;
      tok_line_in  = tok_line_ff;
      tok_col_in   = tok_col_ff;
      tok_len_in   = tok_len_ff;
      err_in       = err_ff;
      res          = '0;
      n            = 2'd0;
      fall         = 1'b0;

      if (in_is_end) begin
         unique case (mode_ff)
            MODE_SLASH: begin
               res[n] = make_rsp(KIND_SLASH, tok_start_ff, tok_len_ff, tok_line_ff,
                                 tok_col_ff, 8'h00, err_in);
               n = n + 2'd1;
            end
            MODE_STRING: begin
               err_in = (err_in == '1) ? err_in : err_in + 1'b1;
               res[n] = make_rsp(KIND_UNTERM, tok_start_ff, tok_len_ff, tok_line_ff,
                                 tok_col_ff, 8'h00, err_in);
               n = n + 2'd1;
               res[n] = make_rsp(KIND_STRING, tok_start_ff, tok_len_ff, tok_line_ff,
                                 tok_col_ff, 8'h00, err_in);
               n = n + 2'd1;
            end
            MODE_INT, MODE_FRAC: begin
               res[n] = make_rsp(KIND_NUMBER, tok_start_ff, tok_len_ff, tok_line_ff,
                                 tok_col_ff, 8'h00, err_in);
               n = n + 2'd1;
            end
            MODE_OP: begin
               res[n] = make_rsp(op_kind(op_ff, 1'b0), tok_start_ff, tok_len_ff,
                                 tok_line_ff, tok_col_ff, 8'h00, err_in);
               n = n + 2'd1;
            end
            default: ;
         endcase
         mode_in = MODE_IDLE;
         op_in   = OP_NONE;
         res[n]  = make_rsp(KIND_EOF, offset_ff, '0, line_ff, col_ff, 8'h00, err_in);
         n = n + 2'd1;
      end else begin
         unique case (mode_ff)
            MODE_SLASH: begin
               if (in_ch == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  res[n] = make_rsp(KIND_SLASH, tok_start_ff, tok_len_ff, tok_line_ff,
                                    tok_col_ff, 8'h00, err_in);
                  n = n + 2'd1;
                  fall = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (in_ch == CH_NL) fall = 1'b1;
            end
            MODE_STRING: begin
               if (in_ch == CH_QUOTE) begin
                  res[n] = make_rsp(KIND_STRING, tok_start_ff, tok_len_ff, tok_line_ff,
                                    tok_col_ff, 8'h00, err_in);
                  n = n + 2'd1;
                  mode_in = MODE_IDLE;
                  op_in   = OP_NONE;
               end else if (in_ch == CH_NL) begin
                  // unterminated: error, then the partial string
                  err_in = (err_in == '1) ? err_in : err_in + 1'b1;
                  res[n] = make_rsp(KIND_UNTERM, tok_start_ff, tok_len_ff, tok_line_ff,
                                    tok_col_ff, 8'h00, err_in);
                  n = n + 2'd1;
                  res[n] = make_rsp(KIND_STRING, tok_start_ff, tok_len_ff, tok_line_ff,
                                    tok_col_ff, 8'h00, err_in);
                  n = n + 2'd1;
                  fall = 1'b1;
               end else begin
                  tok_len_in = len_inc(tok_len_ff);
               end
            end
            MODE_INT, MODE_FRAC: begin
               if (is_digit || (in_ch == CH_DOT && mode_ff == MODE_INT)) begin
                  if (in_ch == CH_DOT) mode_in = MODE_FRAC;
                  tok_len_in = len_inc(tok_len_ff);
               end else begin
                  res[n] = make_rsp(KIND_NUMBER, tok_start_ff, tok_len_ff, tok_line_ff,
                                    tok_col_ff, 8'h00, err_in);
                  n = n + 2'd1;
                  fall = 1'b1;
               end
            end
            MODE_OP: begin
               if (in_ch == CH_EQ) begin
                  tok_len_in = 16'd2;
                  res[n] = make_rsp(op_kind(op_ff, 1'b1), tok_start_ff, tok_len_in,
                                    tok_line_ff, tok_col_ff, 8'h00, err_in);
                  n = n + 2'd1;
                  mode_in = MODE_IDLE;
                  op_in   = OP_NONE;
               end else begin
                  res[n] = make_rsp(op_kind(op_ff, 1'b0), tok_start_ff, tok_len_ff,
                                    tok_line_ff, tok_col_ff, 8'h00, err_in);
                  n = n + 2'd1;
                  fall = 1'b1;
               end
            end
            default: fall = 1'b1;
         endcase

         // Byte not taken by a pending token, or seen from idle: starts a token at the current position
         if (fall) begin
            mode_in      = MODE_IDLE;
            op_in        = OP_NONE;
            tok_start_in = offset_ff;
            tok_line_in  = line_ff;
            tok_col_in   = col_ff;
            tok_len_in   = 16'd1;
            case (in_ch) inside
               CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA,
               CH_DOT, CH_MINUS, CH_PLUS, CH_SEMI, CH_STAR: begin
                  unique case (in_ch)
                     CH_LPAREN: res[n].kind = KIND_LPAREN;
                     CH_RPAREN: res[n].kind = KIND_RPAREN;
                     CH_LBRACE: res[n].kind = KIND_LBRACE;
                     CH_RBRACE: res[n].kind = KIND_RBRACE;
                     CH_COMMA:  res[n].kind = KIND_COMMA;
                     CH_DOT:    res[n].kind = KIND_DOT;
                     CH_MINUS:  res[n].kind = KIND_MINUS;
                     CH_PLUS:   res[n].kind = KIND_PLUS;
                     CH_SEMI:   res[n].kind = KIND_SEMI;
                     default:   res[n].kind = KIND_STAR;
                  endcase
                  res[n] = make_rsp(res[n].kind, offset_ff, 16'd1, line_ff, col_ff,
                                    8'h00, err_in);
                  n = n + 2'd1;
               end
               CH_SLASH:  mode_in = MODE_SLASH;
               CH_QUOTE: begin
                  mode_in    = MODE_STRING;
                  tok_len_in = '0;
               end
               CH_EQ: begin
                  mode_in = MODE_OP;
                  op_in   = OP_EQ;
               end
               CH_BANG: begin
                  mode_in = MODE_OP;
                  op_in   = OP_BANG;
               end
               CH_GT: begin
                  mode_in = MODE_OP;
                  op_in   = OP_GT;
               end
               CH_LT: begin
                  mode_in = MODE_OP;
                  op_in   = OP_LT;
               end
               CH_SPACE, CH_CR, CH_TAB, CH_NL: ;
               [CH_ZERO:CH_NINE]: mode_in = MODE_INT;
               default: begin
                  err_in = (err_in == '1) ? err_in : err_in + 1'b1;
                  res[n] = make_rsp(KIND_BAD_CHAR, offset_ff, 16'd1, line_ff, col_ff,
                                    in_ch, err_in);
                  n = n + 2'd1;
               end
            endcase
         end
      end

      if (n != 2'd0) res[n - 2'd1].last = 1'b1;
   end

   assign scan_out.count = n;
   assign scan_out.item  = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         op_ff        <= OP_NONE;
         tok_start_ff <= '0;
         tok_line_ff  <= '0;
         tok_col_ff   <= '0;
         tok_len_ff   <= '0;
         offset_ff    <= '0;
         line_ff      <= '0;
         col_ff       <= '0;
         err_ff       <= '0;
      end else if (in_accept) begin
         mode_ff      <= mode_in;
         op_ff        <= op_in;
         tok_start_ff <= tok_start_in;
         tok_line_ff  <= tok_line_in;
         tok_col_ff   <= tok_col_in;
         tok_len_ff   <= tok_len_in;
         offset_ff    <= offset_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         err_ff       <= err_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lts_rsp_fifo.sv @@
// Four-entry result queue; takes up to three results per transfer.
`default_nettype none

module lts_rsp_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lts_pkg::scan_out_type wr,
   output logic                      space_ok,
   output logic                      out_valid,
   output lts_pkg::rsp_type          out_item,
   input  wire logic                 out_ready
);
   import lts_pkg::*;

   localparam int DEPTH = 4;

   rsp_type    mem_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] push_n;
   logic       pop;

   assign push_n    = push ? wr.count : 2'd0;
   assign pop       = out_valid && out_ready;
   assign space_ok  = count_ff <= 3'(DEPTH - MAX_RESULTS);
   assign out_valid = count_ff != 3'd0;
   assign out_item  = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + push_n;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push_n} - {2'b00, pop};

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < push_n) mem_ff[wr_ptr_ff + 2'(i)] <= wr.item[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lox_token_scanner: directed table, random source text, scoreboard.
module tb_top;
   import lts_pkg::*;

   // Comparison operator kinds that the package does not name
   localparam logic [4:0] KIND_EQ      = 5'd13;
   localparam logic [4:0] KIND_BANG_EQ = 5'd14;
   localparam logic [4:0] KIND_BANG    = 5'd15;
   localparam logic [4:0] KIND_GT_EQ   = 5'd16;
   localparam logic [4:0] KIND_GT      = 5'd17;
   localparam logic [4:0] KIND_LT_EQ   = 5'd18;
   localparam logic [4:0] KIND_LT      = 5'd19;

   localparam int DIR_ROWS          = 30;
   localparam int RANDOM_ITEMS      = 60;
   localparam int TAIL_CYCLES       = 20;
   localparam int MAX_PRINTS        = 40;
   // Quiet cycles allowed before the watchdog ends the run; set well above the longest
   // receiver hold plus a sender gap.
   localparam int WATCHDOG_LIMIT    = 2000;

   localparam logic [7:0] PUNCT_CHARS [10] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                              CH_COMMA, CH_DOT, CH_MINUS, CH_PLUS,
                                              CH_SEMI, CH_STAR};
   localparam logic [7:0] OP_CHARS [4]     = '{CH_EQ, CH_BANG, CH_GT, CH_LT};
   localparam logic [7:0] BLANK_CHARS [4]  = '{CH_SPACE, CH_CR, CH_TAB, CH_NL};

   typedef enum logic [2:0] {
      LX_IDLE, LX_SLASH, LX_COMMENT, LX_STRING, LX_INT, LX_FRAC, LX_OP
   } lex_mode_type;

   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_HOLD} rx_pattern_type;

   // One row of the directed table; want is used only where typed is set
   typedef struct packed {
      logic [7:0] ch;
      logic       is_end;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;     // [7:0] ch
   logic [0:0]   req_tuser  = '0;     // [0] is_end
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;           // [23:0] start_offset, [39:24] token_length,
                                      // [59:40] line, [75:60] column,
                                      // [83:76] bad_char, [99:84] error_count
   logic [4:0]   rsp_tuser;           // [4:0] token_kind
   logic         rsp_tlast;

   lox_token_scanner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Lexer predictor: its own copy of the scan state, advanced once per source transfer
   // ---------------------------------------------------------------------------------
   lex_mode_type        lx_mode      = LX_IDLE;
   logic [2:0]          lx_op        = OP_NONE;
   logic [START_W-1:0]  lx_tok_start = '0;
   logic [LINE_W-1:0]   lx_tok_line  = '0;
   logic [COLUMN_W-1:0] lx_tok_col   = '0;
   logic [LENGTH_W-1:0] lx_tok_len   = '0;
   logic [START_W-1:0]  lx_offset    = '0;
   logic [LINE_W-1:0]   lx_line      = '0;
   logic [COLUMN_W-1:0] lx_col       = '0;
   logic [ERRCNT_W-1:0] lx_errors    = '0;

   rsp_type step_tokens [$];   // tokens caused by the transfer being predicted
   rsp_type tokens_due [$];    // tokens still owed by the scanner, oldest first

   int mismatches   = 0;
   int results_seen = 0;
   int items_sent   = 0;
   int tx_burst     = 0;

   task emit_token(input logic [4:0] kind, input logic [START_W-1:0] st,
                   input logic [LENGTH_W-1:0] len, input logic [LINE_W-1:0] ln,
                   input logic [COLUMN_W-1:0] col, input logic [7:0] bad);
      rsp_type t;
      if (step_tokens.size() < MAX_RESULTS) begin
         t.last   = 1'b0;
         t.kind   = kind;
         t.start  = st;
         t.length = len;
         t.line   = ln;
         t.column = col;
         t.bad    = bad;
         t.errors = lx_errors;
         step_tokens.insert(step_tokens.size(), t);
      end
   endtask

   task emit_lexeme(input logic [4:0] kind);
      emit_token(kind, lx_tok_start, lx_tok_len, lx_tok_line, lx_tok_col, 8'h00);
   endtask

   task count_error();
      if (lx_errors != '1) lx_errors = lx_errors + 1'b1;
   endtask

   // error first, then whatever string content was collected
   task emit_unterminated();
      count_error();
      emit_lexeme(KIND_UNTERM);
      emit_lexeme(KIND_STRING);
   endtask

   task move_past(input logic [7:0] c);
      if (lx_offset != '1) lx_offset = lx_offset + 1'b1;
      if (c == CH_NL) begin
         if (lx_line != '1) lx_line = lx_line + 1'b1;
         lx_col = '0;
      end else if (lx_col != '1) begin
         lx_col = lx_col + 1'b1;
      end
   endtask

   function automatic logic [4:0] compare_kind(input logic [2:0] op, input logic two);
      case (op)
         OP_BANG: return two ? KIND_BANG_EQ : KIND_BANG;
         OP_GT:   return two ? KIND_GT_EQ : KIND_GT;
         OP_LT:   return two ? KIND_LT_EQ : KIND_LT;
         default: return two ? KIND_EQ_EQ : KIND_EQ;
      endcase
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   task predict_tokens(input logic [7:0] c, input logic is_end);
      logic    fresh;
      rsp_type tail;
      step_tokens.delete();
      fresh = 1'b0;
      if (is_end) begin
         // flush whatever is pending, then EOF at the current position
         case (lx_mode)
            LX_SLASH:        emit_lexeme(KIND_SLASH);
            LX_STRING:       emit_unterminated();
            LX_INT, LX_FRAC: emit_lexeme(KIND_NUMBER);
            LX_OP:           emit_lexeme(compare_kind(lx_op, 1'b0));
            default: ;
         endcase
         lx_mode = LX_IDLE;
         lx_op   = OP_NONE;
         emit_token(KIND_EOF, lx_offset, '0, lx_line, lx_col, 8'h00);
      end else begin
         case (lx_mode)
            LX_SLASH: begin
               if (c == CH_SLASH) begin
                  lx_mode = LX_COMMENT;
                  move_past(c);
               end else begin
                  emit_lexeme(KIND_SLASH);
                  fresh = 1'b1;
               end
            end
            LX_COMMENT: begin
               if (c == CH_NL) fresh = 1'b1;
               else move_past(c);
            end
            LX_STRING: begin
               if (c == CH_QUOTE) begin
                  emit_lexeme(KIND_STRING);
                  lx_mode = LX_IDLE;
                  lx_op   = OP_NONE;
                  move_past(c);
               end else if (c == CH_NL) begin
                  emit_unterminated();
                  fresh = 1'b1;
               end else begin
                  if (lx_tok_len != '1) lx_tok_len = lx_tok_len + 1'b1;
                  move_past(c);
               end
            end
            LX_INT, LX_FRAC: begin
               // one dot right after the integer digits belongs to the number
               if (is_digit(c) || (c == CH_DOT && lx_mode == LX_INT)) begin
                  if (c == CH_DOT) lx_mode = LX_FRAC;
                  if (lx_tok_len != '1) lx_tok_len = lx_tok_len + 1'b1;
                  move_past(c);
               end else begin
                  emit_lexeme(KIND_NUMBER);
                  fresh = 1'b1;
               end
            end
            LX_OP: begin
               if (c == CH_EQ) begin
                  lx_tok_len = 16'd2;
                  emit_lexeme(compare_kind(lx_op, 1'b1));
                  lx_mode = LX_IDLE;
                  lx_op   = OP_NONE;
                  move_past(c);
               end else begin
                  emit_lexeme(compare_kind(lx_op, 1'b0));
                  fresh = 1'b1;
               end
            end
            default: fresh = 1'b1;
         endcase

         // byte not consumed by the pending token: it starts a new one
         if (fresh) begin
            lx_mode      = LX_IDLE;
            lx_op        = OP_NONE;
            lx_tok_start = lx_offset;
            lx_tok_line  = lx_line;
            lx_tok_col   = lx_col;
            lx_tok_len   = 16'd1;
            case (c)
               CH_LPAREN: emit_lexeme(KIND_LPAREN);
               CH_RPAREN: emit_lexeme(KIND_RPAREN);
               CH_LBRACE: emit_lexeme(KIND_LBRACE);
               CH_RBRACE: emit_lexeme(KIND_RBRACE);
               CH_COMMA:  emit_lexeme(KIND_COMMA);
               CH_DOT:    emit_lexeme(KIND_DOT);
               CH_MINUS:  emit_lexeme(KIND_MINUS);
               CH_PLUS:   emit_lexeme(KIND_PLUS);
               CH_SEMI:   emit_lexeme(KIND_SEMI);
               CH_STAR:   emit_lexeme(KIND_STAR);
               CH_SLASH:  lx_mode = LX_SLASH;
               CH_QUOTE: begin
                  lx_mode    = LX_STRING;
                  lx_tok_len = '0;
               end
               CH_EQ: begin
                  lx_mode = LX_OP;
                  lx_op   = OP_EQ;
               end
               CH_BANG: begin
                  lx_mode = LX_OP;
                  lx_op   = OP_BANG;
               end
               CH_GT: begin
                  lx_mode = LX_OP;
                  lx_op   = OP_GT;
               end
               CH_LT: begin
                  lx_mode = LX_OP;
                  lx_op   = OP_LT;
               end
               CH_SPACE, CH_CR, CH_TAB, CH_NL: ;
               default: begin
                  if (is_digit(c)) begin
                     lx_mode = LX_INT;
                  end else begin
                     count_error();
                     emit_token(KIND_BAD_CHAR, lx_tok_start, 16'd1, lx_tok_line,
                                lx_tok_col, c);
                  end
               end
            endcase
            move_past(c);
         end
      end

      if (step_tokens.size() > 0) begin
         tail      = step_tokens[step_tokens.size() - 1];
         tail.last = 1'b1;
         step_tokens[step_tokens.size() - 1] = tail;
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Source side: bursts of random length, random gaps between bursts
   // ---------------------------------------------------------------------------------
   task send_item(input logic [7:0] ch, input logic is_end,
                  input logic use_want = 1'b0, input rsp_type want = '0);
      int gap;
      if (tx_burst == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            gap      = 0;          // a stretch with no idling
            tx_burst = 48;
         end else begin
            gap      = $urandom_range(0, 5);
            tx_burst = $urandom_range(1, 16);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      tx_burst = tx_burst - 1;

      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= is_end;
      do @(posedge clock); while (!req_tready);

      // transfer taken at this edge: book what it owes
      items_sent = items_sent + 1;
      predict_tokens(ch, is_end);
      if (use_want) begin
         tokens_due.insert(tokens_due.size(), want);
      end else begin
         foreach (step_tokens[k]) tokens_due.insert(tokens_due.size(), step_tokens[k]);
      end
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_NL);
      return b;
   endfunction

   // One lexeme of random content, mostly well formed, with some noise
   task send_lexeme();
      int pick;
      int n;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         send_item(PUNCT_CHARS[$urandom_range(0, 9)], 1'b0);
      end else if (pick < 30) begin
         send_item(OP_CHARS[$urandom_range(0, 3)], 1'b0);
         if ($urandom_range(0, 1) == 1) send_item(CH_EQ, 1'b0);
      end else if (pick < 35) begin
         send_item(CH_SLASH, 1'b0);
      end else if (pick < 43) begin
         send_item(CH_SLASH, 1'b0);
         send_item(CH_SLASH, 1'b0);
         n = $urandom_range(0, 6);
         repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
            send_item(b, 1'b0);
         end
         if ($urandom_range(0, 3) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
         else send_item(CH_NL, 1'b0);
      end else if (pick < 55) begin
         send_item(CH_QUOTE, 1'b0);
         n = $urandom_range(0, 8);
         repeat (n) send_item(text_byte(), 1'b0);
         send_item(CH_QUOTE, 1'b0);
      end else if (pick < 60) begin
         // string broken by a newline or by the end mark
         send_item(CH_QUOTE, 1'b0);
         n = $urandom_range(0, 5);
         repeat (n) send_item(text_byte(), 1'b0);
         if ($urandom_range(0, 1) == 1) send_item(CH_NL, 1'b0);
         else send_item(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 75) begin
         n = $urandom_range(1, 4);
         repeat (n) send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
         if ($urandom_range(0, 4) < 2) begin
            send_item(CH_DOT, 1'b0);
            n = $urandom_range(0, 3);
            repeat (n) send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
         end
      end else if (pick < 85) begin
         send_item(BLANK_CHARS[$urandom_range(0, 3)], 1'b0);
      end else if (pick < 95) begin
         send_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Result side: stall pattern in segments, and the scoreboard check
   // ---------------------------------------------------------------------------------
   task report_mismatch(input string what, input rsp_type want, input rsp_type got);
      if (mismatches < MAX_PRINTS)
         $display("MISMATCH token %0d (%s): expected %h got %h",
                  results_seen, what, want, got);
      mismatches = mismatches + 1;
   endtask

   rx_pattern_type rx_mode  = RX_OPEN;
   int             rx_left  = 0;
   int             rx_phase = 0;

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      string   diff;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.last   = rsp_tlast;
         got.kind   = rsp_tuser;
         got.start  = rsp_tdata[23:0];
         got.length = rsp_tdata[39:24];
         got.line   = rsp_tdata[59:40];
         got.column = rsp_tdata[75:60];
         got.bad    = rsp_tdata[83:76];
         got.errors = rsp_tdata[99:84];
         if (tokens_due.size() == 0) begin
            report_mismatch("nothing expected", '0, got);
         end else begin
            want = tokens_due.pop_front();
            diff = "";
            if (got.kind   != want.kind)   diff = {diff, " kind"};
            if (got.start  != want.start)  diff = {diff, " start"};
            if (got.length != want.length) diff = {diff, " length"};
            if (got.line   != want.line)   diff = {diff, " line"};
            if (got.column != want.column) diff = {diff, " column"};
            if (got.bad    != want.bad)    diff = {diff, " bad_char"};
            if (got.errors != want.errors) diff = {diff, " errors"};
            if (got.last   != want.last)   diff = {diff, " last"};
            if (diff != "") report_mismatch(diff, want, got);
         end
         results_seen = results_seen + 1;
      end

      // new segment: open, random, periodic, or a short hard hold
      if (rx_left == 0) begin
         rx_mode = rx_pattern_type'($urandom_range(0, 3));
         rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 24) : $urandom_range(8, 64);
      end
      rx_left  = rx_left - 1;
      rx_phase = rx_phase + 1;
      case (rx_mode)
         RX_OPEN:     rsp_tready <= 1'b1;
         RX_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_PERIODIC: rsp_tready <= (rx_phase % 3 != 0);
         default:     rsp_tready <= 1'b0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Watchdog: ends the run if no transfer happens on either side for too long
   // ---------------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet = quiet + 1;
      end
      $display("watchdog: no transfer for %0d cycles, %0d tokens outstanding",
               WATCHDOG_LIMIT, tokens_due.size());
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------
   function automatic stim_row_type byte_row(input logic [7:0] ch, input logic is_end = 1'b0);
      stim_row_type r;
      r        = '0;
      r.ch     = ch;
      r.is_end = is_end;
      return r;
   endfunction

   // row whose single token is written out by hand
   function automatic stim_row_type token_row(input logic [7:0] ch, input logic is_end,
                                              input logic [4:0] kind, input int st,
                                              input int len, input int ln, input int col,
                                              input logic [7:0] bad, input int errs);
      stim_row_type r;
      r             = byte_row(ch, is_end);
      r.typed       = 1'b1;
      r.want.last   = 1'b1;
      r.want.kind   = kind;
      r.want.start  = START_W'(st);
      r.want.length = LENGTH_W'(len);
      r.want.line   = LINE_W'(ln);
      r.want.column = COLUMN_W'(col);
      r.want.bad    = bad;
      r.want.errors = ERRCNT_W'(errs);
      return r;
   endfunction

   initial begin : stimulus
      stim_row_type dir_rows [DIR_ROWS];
      int           target;

      // Directed source: byte extremes, every one-character token, some comparisons, comment,
      // broken string, number with a fraction, end inside a string, and a bare end.
      dir_rows = '{
         token_row(CH_LPAREN, 1'b0, KIND_LPAREN, 0, 1, 0, 0, 8'h00, 0),
         token_row(8'h00, 1'b0, KIND_BAD_CHAR, 1, 1, 0, 1, 8'h00, 1),
         token_row(8'hFF, 1'b0, KIND_BAD_CHAR, 2, 1, 0, 2, 8'hFF, 2),
         byte_row(CH_RPAREN), byte_row(CH_LBRACE), byte_row(CH_RBRACE),
         byte_row(CH_COMMA), byte_row(CH_DOT), byte_row(CH_MINUS),
         byte_row(CH_PLUS), byte_row(CH_SEMI), byte_row(CH_STAR),
         byte_row(CH_EQ), byte_row(CH_EQ),                       // ==
         byte_row(CH_BANG), byte_row(CH_GT), byte_row(CH_EQ),    // ! then >=
         byte_row(CH_LT), byte_row(CH_SLASH),                    // < then slash pending
         byte_row(CH_SLASH), byte_row(CH_NL),                    // empty line comment
         byte_row(CH_QUOTE), byte_row(8'h61), byte_row(CH_NL),   // string cut by newline
         byte_row(CH_ZERO + 8'd7), byte_row(CH_DOT), byte_row(CH_ZERO + 8'd5),
         byte_row(CH_QUOTE),                                     // 7.5 then open string
         byte_row(8'hFF, 1'b1),                                  // end inside string
         token_row(8'h00, 1'b1, KIND_EOF, 28, 0, 2, 4, 8'h00, 4)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].ch, dir_rows[i].is_end, dir_rows[i].typed, dir_rows[i].want);

      // Random source text; halfway the sender holds off until every token is back
      target = items_sent + RANDOM_ITEMS / 2;
      while (items_sent < target) send_lexeme();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tokens_due.size() != 0);
      tx_burst = 0;
      target = items_sent + RANDOM_ITEMS / 2;
      while (items_sent < target) send_lexeme();

      // String cut by the end mark, then a little more text and a final end
      send_item(CH_QUOTE, 1'b0);
      send_item(8'h78, 1'b0);
      send_item(8'h00, 1'b1);
      repeat (4) send_lexeme();
      send_item(8'($urandom_range(0, 255)), 1'b1);

      req_tvalid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && tokens_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
